@@ hw/rtl/bpa_pkg.sv @@
package bpa_pkg;

    localparam int FUNC_W  = 2;
    localparam int ORDER_W = 4;
    localparam int CFG_W   = 13;
    localparam logic [CFG_W-1:0] TOTAL_RST = 13'd4096;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_SEED  = 2'd2,
        FN_NONE  = 2'd3
    } bpa_func_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_MARK,
        ST_A_SRCH,
        ST_A_POPW,
        ST_A_SPLIT,
        ST_A_SPUSH,
        ST_M_CHK,
        ST_M_USED,
        ST_T_STEP,
        ST_T_NEXT,
        ST_T_UNLINK,
        ST_PUSH,
        ST_S_NEXT,
        ST_S_ALN,
        ST_S_FIT,
        ST_S_PUSH,
        ST_DONE
    } bpa_state_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic ok;
    } bpa_stat_t;

endpackage

@@ hw/rtl/bpa_ram.sv @@
module bpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
module bpa_ctrl #(
    parameter int PAGES = 4096,
    parameter int MAX_ORDER = 10,
    localparam int PW = $clog2(PAGES),
    localparam int CW = PW + 1,
    localparam int OW = $clog2(MAX_ORDER + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bpa_pkg::FUNC_W-1:0] func,
    input  logic [bpa_pkg::ORDER_W-1:0] order,
    input  logic [PW-1:0]              page,
    input  logic [CW-1:0]              range_end,
    input  logic [CW-1:0]              managed,
    input  logic                       res_free,
    output bpa_pkg::bpa_stat_t         stat,
    output logic [PW-1:0]              granted,
    output logic [CW-1:0]              free_cnt,
    output logic                       u_we,
    output logic [PW-1:0]              u_waddr,
    output logic                       u_wdata,
    output logic [PW-1:0]              u_raddr,
    input  logic                       u_rdata,
    output logic                       n_we,
    output logic [PW-1:0]              n_waddr,
    output logic [CW-1:0]              n_wdata,
    output logic [PW-1:0]              n_raddr,
    input  logic [CW-1:0]              n_rdata
);

    import bpa_pkg::*;

    localparam logic [CW-1:0] EMPTY = CW'(PAGES);
    localparam int HN = MAX_ORDER + 1;

    bpa_state_t    state_reg, state_next;
    bpa_func_t     func_reg, func_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic [OW-1:0] rord_reg, rord_next;
    logic [PW-1:0] pg_reg, pg_next;
    logic [CW-1:0] end_reg, end_next;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic [PW-1:0] bud_reg, bud_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ok_reg, ok_next;
    logic [PW-1:0] grant_reg, grant_next;
    logic          mval_reg, mval_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [CW-1:0] head_reg [HN];

    logic          head_we;
    logic [CW-1:0] head_wd;
    logic [CW-1:0] head_sel;
    logic [CW-1:0] size_w;
    logic [CW-1:0] in_size;
    logic          in_ord_bad;
    logic          in_mis;
    logic          in_oob;
    logic          seed_oob;
    logic          scan_end;
    logic          ord_max;
    logic [PW-1:0] bud_c;
    logic          bud_oob;
    logic [CW-1:0] rem;
    logic          aln_bad;
    logic          fit_bad;
    logic [PW-1:0] half;

    always_comb
    begin
        head_sel   = head_reg[ord_reg];
        size_w     = CW'(1) << ord_reg;
        in_size    = CW'(1) << order;
        in_ord_bad = int'(order) > MAX_ORDER;
        in_mis     = ({1'b0, page} & (in_size - CW'(1))) != '0;
        in_oob     = ({2'b0, page} + {1'b0, in_size}) > {1'b0, managed};
        seed_oob   = range_end > managed;
        scan_end   = idx_reg >= lim_reg;
        ord_max    = ord_reg == OW'(MAX_ORDER);
        bud_c      = pg_reg ^ size_w[PW-1:0];
        bud_oob    = ({2'b0, bud_c} + {1'b0, size_w}) > {1'b0, managed};
        rem        = end_reg - base_reg;
        aln_bad    = (base_reg != '0) && ((base_reg & (size_w - CW'(1))) != '0);
        fit_bad    = size_w > rem;
        half       = pg_reg + size_w[PW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == PW'(PAGES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (bpa_func_t'(func))
                        FN_ALLOC: state_next = in_ord_bad ? ST_DONE : ST_A_SRCH;
                        FN_FREE:  state_next = (in_ord_bad || in_mis || in_oob) ?
                                               ST_DONE : ST_SCAN_RD;
                        FN_SEED:  state_next = seed_oob ? ST_DONE : ST_SCAN_RD;
                        FN_NONE:  state_next = ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                if (!scan_end)
                begin
                    state_next = ST_SCAN_CK;
                end
                else if (func_reg == FN_FREE)
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = ST_S_NEXT;
                end
            end
            ST_SCAN_CK:  state_next = u_rdata ? ST_SCAN_RD : ST_DONE;
            ST_MARK:
            begin
                if (scan_end)
                begin
                    priority case (func_reg)
                        FN_FREE: state_next = ST_M_CHK;
                        FN_SEED: state_next = ST_S_PUSH;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_A_SRCH:
            begin
                if (head_sel < EMPTY)
                begin
                    state_next = ST_A_POPW;
                end
                else if (ord_max)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_A_POPW:   state_next = ST_A_SPLIT;
            ST_A_SPLIT:  state_next = (ord_reg > rord_reg) ? ST_A_SPUSH : ST_MARK;
            ST_A_SPUSH:  state_next = ST_A_SPLIT;
            ST_M_CHK:    state_next = (ord_max || bud_oob) ? ST_PUSH : ST_M_USED;
            ST_M_USED:   state_next = u_rdata ? ST_PUSH : ST_T_STEP;
            ST_T_STEP:
            begin
                if (cur_reg >= EMPTY)
                begin
                    state_next = ST_PUSH;
                end
                else if (cur_reg[PW-1:0] == bud_reg)
                begin
                    state_next = ST_T_UNLINK;
                end
                else
                begin
                    state_next = ST_T_NEXT;
                end
            end
            ST_T_NEXT:   state_next = ST_T_STEP;
            ST_T_UNLINK: state_next = ST_M_CHK;
            ST_PUSH:     state_next = ST_DONE;
            ST_S_NEXT:   state_next = (base_reg >= end_reg) ? ST_DONE : ST_S_ALN;
            ST_S_ALN:
            begin
                if (!(ord_reg != '0 && aln_bad))
                begin
                    state_next = ST_S_FIT;
                end
            end
            ST_S_FIT:
            begin
                if (!(ord_reg != '0 && fit_bad))
                begin
                    state_next = ST_MARK;
                end
            end
            ST_S_PUSH:   state_next = ST_S_NEXT;
            ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // memory ports and status
    always_comb
    begin
        u_we    = 1'b0;
        u_waddr = idx_reg[PW-1:0];
        u_wdata = mval_reg;
        u_raddr = idx_reg[PW-1:0];
        n_we    = 1'b0;
        n_waddr = pg_reg;
        n_wdata = head_sel;
        n_raddr = cur_reg[PW-1:0];
        head_we = 1'b0;
        head_wd = n_rdata;
        stat.idle = state_reg == ST_IDLE;
        stat.done = state_reg == ST_DONE;
        stat.ok   = ok_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                u_we    = 1'b1;
                u_waddr = clr_reg;
                u_wdata = 1'b1;
            end
            ST_MARK:     u_we = !scan_end;
            ST_A_SRCH:   n_raddr = head_sel[PW-1:0];
            ST_A_POPW:   head_we = 1'b1;
            ST_A_SPUSH:
            begin
                n_we    = 1'b1;
                n_waddr = half;
                head_we = 1'b1;
                head_wd = {1'b0, half};
            end
            ST_M_CHK:    u_raddr = bud_c;
            ST_T_UNLINK:
            begin
                if (prev_reg == EMPTY)
                begin
                    head_we = 1'b1;
                end
                else
                begin
                    n_we    = 1'b1;
                    n_waddr = prev_reg[PW-1:0];
                    n_wdata = n_rdata;
                end
            end
            ST_PUSH:
            begin
                n_we    = 1'b1;
                head_we = 1'b1;
                head_wd = {1'b0, pg_reg};
            end
            ST_S_PUSH:
            begin
                n_we    = 1'b1;
                n_waddr = base_reg[PW-1:0];
                head_we = 1'b1;
                head_wd = base_reg;
            end
            default:
            begin
                u_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        func_next  = func_reg;
        ord_next   = ord_reg;
        rord_next  = rord_reg;
        pg_next    = pg_reg;
        end_next   = end_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        bud_next   = bud_reg;
        cnt_next   = cnt_reg;
        ok_next    = ok_reg;
        grant_next = grant_reg;
        mval_next  = mval_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:    clr_next = clr_reg + PW'(1);
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = bpa_func_t'(func);
                    ord_next   = OW'(order);
                    rord_next  = OW'(order);
                    pg_next    = page;
                    end_next   = range_end;
                    base_next  = {1'b0, page};
                    idx_next   = {1'b0, page};
                    lim_next   = (bpa_func_t'(func) == FN_FREE) ?
                                 ({1'b0, page} + in_size) : range_end;
                    ok_next    = 1'b0;
                    grant_next = '0;
                end
            end
            ST_SCAN_RD:
            begin
                if (scan_end && func_reg == FN_FREE)
                begin
                    idx_next  = {1'b0, pg_reg};
                    lim_next  = {1'b0, pg_reg} + size_w;
                    mval_next = 1'b0;
                    cnt_next  = cnt_reg + size_w;
                end
            end
            ST_SCAN_CK:  idx_next = idx_reg + CW'(1);
            ST_MARK:
            begin
                if (!scan_end)
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_A_SRCH:
            begin
                if (head_sel < EMPTY)
                begin
                    pg_next = head_sel[PW-1:0];
                end
                else if (!ord_max)
                begin
                    ord_next = ord_reg + OW'(1);
                end
            end
            ST_A_SPLIT:
            begin
                if (ord_reg > rord_reg)
                begin
                    ord_next = ord_reg - OW'(1);
                end
                else
                begin
                    idx_next   = {1'b0, pg_reg};
                    lim_next   = {1'b0, pg_reg} + size_w;
                    mval_next  = 1'b1;
                    cnt_next   = cnt_reg - size_w;
                    grant_next = pg_reg;
                    ok_next    = 1'b1;
                end
            end
            ST_M_CHK:    bud_next = bud_c;
            ST_M_USED:
            begin
                cur_next  = head_sel;
                prev_next = EMPTY;
            end
            ST_T_NEXT:
            begin
                prev_next = cur_reg;
                cur_next  = n_rdata;
            end
            ST_T_UNLINK:
            begin
                pg_next  = pg_reg & ~size_w[PW-1:0];
                ord_next = ord_reg + OW'(1);
            end
            ST_PUSH:     ok_next = 1'b1;
            ST_S_NEXT:
            begin
                if (base_reg >= end_reg)
                begin
                    ok_next = 1'b1;
                end
                else
                begin
                    ord_next = OW'(MAX_ORDER);
                end
            end
            ST_S_ALN:
            begin
                if (ord_reg != '0 && aln_bad)
                begin
                    ord_next = ord_reg - OW'(1);
                end
            end
            ST_S_FIT:
            begin
                if (ord_reg != '0 && fit_bad)
                begin
                    ord_next = ord_reg - OW'(1);
                end
                else
                begin
                    idx_next  = base_reg;
                    lim_next  = base_reg + size_w;
                    mval_next = 1'b0;
                    cnt_next  = cnt_reg + size_w;
                end
            end
            ST_S_PUSH:   base_next = base_reg + size_w;
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            ok_reg    <= 1'b0;
            for (int i = 0; i < HN; i++)
            begin
                head_reg[i] <= EMPTY;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            ok_reg    <= ok_next;
            if (head_we)
            begin
                head_reg[ord_reg] <= head_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        ord_reg   <= ord_next;
        rord_reg  <= rord_next;
        pg_reg    <= pg_next;
        end_reg   <= end_next;
        base_reg  <= base_next;
        idx_reg   <= idx_next;
        lim_reg   <= lim_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        bud_reg   <= bud_next;
        grant_reg <= grant_next;
        mval_reg  <= mval_next;
    end

    assign granted  = grant_reg;
    assign free_cnt = cnt_reg;

endmodule

@@ hw/rtl/buddy_page_allocator_unit.sv @@
// channel  direction  words                              handshake
// in       input      func, order, page, range_end       in_valid / in_ready
// out      output     ok, granted_page, pages_left       out_valid / out_ready
// cfg      input      page limit via cfg_wdata           cfg_we, no wait
// after reset a clearing pass marks every page used, with in_ready low
// allocate: search orders upward for a free block, split it down, then mark its pages used
// free: check each page is used, mark the pages free, then walk the list at each merge level
// seed: check each page is used, then per block pick the largest aligned order that fits and mark its pages free
// the used map and link memories each have one write port and one registered read port; those ports set the rate
// a finished word waits in the output register while the next word is taken
module buddy_page_allocator_unit #(
    parameter int PAGES = 4096,
    parameter int MAX_ORDER = 10,
    localparam int PW = $clog2(PAGES),
    localparam int CW = PW + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bpa_pkg::FUNC_W-1:0]  func,
    input  logic [bpa_pkg::ORDER_W-1:0] order,
    input  logic [PW-1:0]               page,
    input  logic [CW-1:0]               range_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic [PW-1:0]               granted_page,
    output logic [CW-1:0]               pages_left,
    input  logic                        cfg_we,
    input  logic [bpa_pkg::CFG_W-1:0]   cfg_wdata
);

    import bpa_pkg::*;

    logic [CFG_W-1:0] total_reg;
    logic [CW-1:0]    managed;
    logic             out_valid_reg;
    logic             res_ok_reg;
    logic [PW-1:0]    res_page_reg;
    logic [CW-1:0]    res_free_reg;
    logic             res_free;
    logic             start;
    bpa_stat_t        stat;
    logic [PW-1:0]    granted;
    logic [CW-1:0]    free_cnt;

    logic             u_we;
    logic [PW-1:0]    u_waddr;
    logic             u_wdata;
    logic [PW-1:0]    u_raddr;
    logic             u_rdata;
    logic             n_we;
    logic [PW-1:0]    n_waddr;
    logic [CW-1:0]    n_wdata;
    logic [PW-1:0]    n_raddr;
    logic [CW-1:0]    n_rdata;

    assign managed  = (int'(total_reg) < PAGES) ? CW'(total_reg) : CW'(PAGES);
    assign in_ready = stat.idle;
    assign start    = in_valid && in_ready;
    assign res_free = !out_valid_reg || out_ready;

    bpa_ram #(.WIDTH(1), .DEPTH(PAGES)) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    bpa_ram #(.WIDTH(CW), .DEPTH(PAGES)) u_link_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    bpa_ctrl #(.PAGES(PAGES), .MAX_ORDER(MAX_ORDER)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .order     (order),
        .page      (page),
        .range_end (range_end),
        .managed   (managed),
        .res_free  (res_free),
        .stat      (stat),
        .granted   (granted),
        .free_cnt  (free_cnt),
        .u_we      (u_we),
        .u_waddr   (u_waddr),
        .u_wdata   (u_wdata),
        .u_raddr   (u_raddr),
        .u_rdata   (u_rdata),
        .n_we      (n_we),
        .n_waddr   (n_waddr),
        .n_wdata   (n_wdata),
        .n_raddr   (n_raddr),
        .n_rdata   (n_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            if (stat.done && res_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done && res_free)
        begin
            res_ok_reg   <= stat.ok;
            res_page_reg <= granted;
            res_free_reg <= free_cnt;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = res_ok_reg;
    assign granted_page = res_page_reg;
    assign pages_left   = res_free_reg;

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !stat.idle)
        else $error("accepted word did not start the sequencer");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && res_free |=> out_valid)
        else $error("finished word not placed in output register");

    a_fail_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> granted_page == '0)
        else $error("failed word carries a page");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(free_cnt) <= PAGES)
        else $error("free count beyond page total");

endmodule
